### sv/cdrv_pkg.sv
package cdrv_pkg;

    localparam int unsigned YearMin   = 1900;
    localparam int unsigned YearMax   = 2100;
    localparam int unsigned YearShift = 400;
    localparam int unsigned DaysYear  = 365;
    localparam int unsigned Recip25   = 5243;
    localparam int unsigned RecipSh   = 17;
    localparam logic [7:0]  MaxDaysRst = 8'd30;

    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StBadDate = 3'd1;
    localparam logic [2:0] StOrder   = 3'd2;
    localparam logic [2:0] StFuture  = 3'd3;
    localparam logic [2:0] StTooLong = 3'd4;
    localparam logic [2:0] StBadDays = 3'd5;

    // year shifted by one era, and day of year plus one
    typedef struct packed {
        logic [14:0] yr;
        logic [8:0]  doy;
    } civil_t;

    typedef struct packed {
        logic              bad;
        logic signed [7:0] req;
        civil_t            s;
        civil_t            e;
        civil_t            t;
    } front_t;

    typedef struct packed {
        logic [23:0] y365;
        logic [12:0] y4;
        logic [25:0] p100;
        logic [23:0] p400;
        logic [8:0]  doy;
    } prod_t;

    typedef struct packed {
        logic              bad;
        logic signed [7:0] req;
        prod_t             s;
        prod_t             e;
        prod_t             t;
    } prods_t;

    typedef struct packed {
        logic              bad;
        logic signed [7:0] req;
        logic [22:0]       s_ser;
        logic [22:0]       e_ser;
        logic [22:0]       t_ser;
    } serial_t;

    // days before the month in a year that starts in march
    function automatic logic [8:0] cum_days(input logic [6:0] m);
        logic [8:0] r;
        case (m)
            7'd0:    r = 9'd275;
            7'd1:    r = 9'd306;
            7'd2:    r = 9'd337;
            7'd3:    r = 9'd0;
            7'd4:    r = 9'd31;
            7'd5:    r = 9'd61;
            7'd6:    r = 9'd92;
            7'd7:    r = 9'd122;
            7'd8:    r = 9'd153;
            7'd9:    r = 9'd184;
            7'd10:   r = 9'd214;
            7'd11:   r = 9'd245;
            7'd12:   r = 9'd275;
            7'd13:   r = 9'd306;
            7'd14:   r = 9'd337;
            7'd15:   r = 9'd367;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [6:0] m, input logic lp);
        logic [4:0] r;
        case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                   r = 5'd30;
            7'd2:                                       r = lp ? 5'd29 : 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic valid_date(input logic [13:0] y, input logic [6:0] m,
                                        input logic [6:0] d);
        logic lp;
        lp = (y[1:0] == 2'd0) && (y != 14'(YearMin)) && (y != 14'(YearMax));
        return (y >= 14'(YearMin)) && (y <= 14'(YearMax)) && (m >= 7'd1) && (m <= 7'd12)
            && (d >= 7'd1) && (d <= {2'd0, month_len(m, lp)});
    endfunction

    function automatic civil_t to_civil(input logic [13:0] y, input logic [6:0] m,
                                        input logic [6:0] d);
        civil_t c;
        c.yr  = {1'b0, y} + 15'(YearShift) - {14'd0, (m <= 7'd2)};
        c.doy = cum_days(m) + {2'd0, d};
        return c;
    endfunction

    function automatic prod_t to_prod(input civil_t c);
        prod_t p;
        p.y365 = {9'd0, c.yr} * 24'(DaysYear);
        p.y4   = c.yr[14:2];
        p.p100 = {13'd0, c.yr[14:2]} * 26'(Recip25);
        p.p400 = {13'd0, c.yr[14:4]} * 24'(Recip25);
        p.doy  = c.doy;
        return p;
    endfunction

    function automatic logic [22:0] to_serial(input prod_t p);
        logic [8:0] q100;
        logic [6:0] q400;
        q100 = p.p100[RecipSh +: 9];
        q400 = p.p400[RecipSh +: 7];
        return p.y365[22:0] + {10'd0, p.y4} - {14'd0, q100} + {16'd0, q400}
            + {14'd0, p.doy};
    endfunction

endpackage

### sv/cdrv_front.sv
module cdrv_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                sp,
    input  logic [13:0]         sy,
    input  logic [6:0]          sm,
    input  logic [6:0]          sd,
    input  logic                ep,
    input  logic [13:0]         ey,
    input  logic [6:0]          em,
    input  logic [6:0]          ed,
    input  logic [13:0]         ty,
    input  logic [3:0]          tm,
    input  logic [4:0]          td,
    input  logic signed [7:0]   req,
    output logic                out_valid,
    input  logic                out_ready,
    output cdrv_pkg::front_t    out_data
);

    logic             valid_reg;
    cdrv_pkg::front_t data_reg;
    cdrv_pkg::front_t data_next;
    logic [13:0]      ay, by;
    logic [6:0]       am, ad, bm, bd;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        ay = sy; am = sm; ad = sd;
        by = ey; bm = em; bd = ed;
        if (!sp && !ep) begin
            ay = ty; am = {3'd0, tm}; ad = {2'd0, td};
            by = ty; bm = {3'd0, tm}; bd = {2'd0, td};
        end else if (!sp) begin
            ay = ey; am = em; ad = ed;
        end else if (!ep) begin
            by = sy; bm = sm; bd = sd;
        end
        data_next.bad = !cdrv_pkg::valid_date(ay, am, ad) || !cdrv_pkg::valid_date(by, bm, bd);
        data_next.req = req;
        data_next.s   = cdrv_pkg::to_civil(ay, am, ad);
        data_next.e   = cdrv_pkg::to_civil(by, bm, bd);
        data_next.t   = cdrv_pkg::to_civil(ty, {3'd0, tm}, {2'd0, td});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

### sv/cdrv_serial.sv
module cdrv_serial (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  cdrv_pkg::front_t    in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cdrv_pkg::serial_t   out_data
);

    logic              prod_valid_reg;
    cdrv_pkg::prods_t  prod_reg;
    cdrv_pkg::prods_t  prod_next;
    logic              ser_valid_reg;
    cdrv_pkg::serial_t ser_reg;
    cdrv_pkg::serial_t ser_next;
    logic              prod_ready;
    logic              ser_ready;

    assign ser_ready  = !ser_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || ser_ready;
    assign in_ready   = prod_ready;
    assign out_valid  = ser_valid_reg;
    assign out_data   = ser_reg;

    // multiplier stage
    always_comb begin
        prod_next.bad = in_data.bad;
        prod_next.req = in_data.req;
        prod_next.s   = cdrv_pkg::to_prod(in_data.s);
        prod_next.e   = cdrv_pkg::to_prod(in_data.e);
        prod_next.t   = cdrv_pkg::to_prod(in_data.t);
    end

    // sum stage
    always_comb begin
        ser_next.bad   = prod_reg.bad;
        ser_next.req   = prod_reg.req;
        ser_next.s_ser = cdrv_pkg::to_serial(prod_reg.s);
        ser_next.e_ser = cdrv_pkg::to_serial(prod_reg.e);
        ser_next.t_ser = cdrv_pkg::to_serial(prod_reg.t);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            ser_valid_reg  <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= in_valid;
            end
            if (ser_ready) begin
                ser_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready) begin
            prod_reg <= prod_next;
        end
        if (ser_ready) begin
            ser_reg <= ser_next;
        end
    end

endmodule

### sv/cdrv_check.sv
module cdrv_check (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          max_days,
    input  logic                in_valid,
    output logic                in_ready,
    input  cdrv_pkg::serial_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          status,
    output logic [7:0]          span_days
);

    logic        valid_reg;
    logic [2:0]  status_reg;
    logic [2:0]  status_next;
    logic [7:0]  span_reg;
    logic [7:0]  span_next;
    logic [22:0] span;
    logic [22:0] lim;
    logic [22:0] req_ext;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign span_days = span_reg;

    always_comb begin
        span    = in_data.e_ser - in_data.s_ser + 23'd1;
        lim     = {15'd0, max_days};
        req_ext = {16'd0, in_data.req[6:0]};
        span_next = 8'd0;
        if (in_data.bad) begin
            status_next = cdrv_pkg::StBadDate;
        end else if (in_data.e_ser < in_data.s_ser) begin
            status_next = cdrv_pkg::StOrder;
        end else if (in_data.e_ser > in_data.t_ser) begin
            status_next = cdrv_pkg::StFuture;
        end else if (span > lim) begin
            status_next = cdrv_pkg::StTooLong;
        end else if (in_data.req[7] || (req_ext > lim)
                     || ((req_ext != 23'd0) && (req_ext != span))) begin
            status_next = cdrv_pkg::StBadDays;
        end else begin
            status_next = cdrv_pkg::StOk;
            span_next   = span[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            status_reg <= status_next;
            span_reg   <= span_next;
        end
    end

endmodule

### sv/civil_date_range_validator_unit.sv
// Date range checker: one request per clock while m_tready does not stall the result.
// Dates are selected and validated in the first stage, converted to day serials by a
// multiplier stage and a sum stage (reciprocal multiplies stand in for the divisions by
// 100 and 400), and ordered, bounded and compared against max_days in the last stage,
// which is also the output register. Each stage holds its request on its own, so a
// stalled result leaves room upstream for new requests. max_days resets to 30; the user
// must write it through the cfg channel while no request is in flight; not enforced.
module civil_date_range_validator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_yr, first_mon, first_dom, last_yr, last_mon, last_dom,
    // now_yr, now_mon, now_dom, requested_days, zero pad
    input  logic [87:0] s_tdata,
    // start_present, end_present
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status, span_days, zero pad
    output logic [15:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    logic [7:0]        max_days_reg;
    logic              f_valid, f_ready;
    cdrv_pkg::front_t  f_data;
    logic              s_valid, s_ready;
    cdrv_pkg::serial_t s_data;
    logic [2:0]        status;
    logic [7:0]        span_days;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {5'd0, span_days, status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_days_reg <= cdrv_pkg::MaxDaysRst;
        end else if (cfg_valid) begin
            max_days_reg <= cfg_data;
        end
    end

    cdrv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .sp        (s_tuser[0]),
        .sy        (s_tdata[13:0]),
        .sm        (s_tdata[20:14]),
        .sd        (s_tdata[27:21]),
        .ep        (s_tuser[1]),
        .ey        (s_tdata[41:28]),
        .em        (s_tdata[48:42]),
        .ed        (s_tdata[55:49]),
        .ty        (s_tdata[69:56]),
        .tm        (s_tdata[73:70]),
        .td        (s_tdata[78:74]),
        .req       (s_tdata[86:79]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    cdrv_serial u_serial (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (s_valid),
        .out_ready (s_ready),
        .out_data  (s_data)
    );

    cdrv_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_days  (max_days_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .span_days (span_days)
    );

endmodule
